// File: rtl/mnst_pkg.sv
// Shared types and constants of the MIDI note state tracker.
`timescale 1ns / 1ps

package mnst_pkg;

	localparam int NUM_CHANNELS = 16;
	localparam int NUM_NOTES    = 128;
	localparam int NOTE_ROWS    = NUM_CHANNELS * 2;
	localparam int NOTE_AW      = $clog2(NOTE_ROWS);
	localparam int CTRL_DEPTH   = NUM_CHANNELS * NUM_NOTES;
	localparam int CTRL_AW      = $clog2(CTRL_DEPTH);
	localparam int WORD_W       = 64;
	localparam int POS_W        = $clog2(WORD_W);

	// message types (high nibble of the status byte)
	localparam logic [3:0] MSG_NOTE_OFF = 4'h8;
	localparam logic [3:0] MSG_NOTE_ON  = 4'h9;
	localparam logic [3:0] MSG_CTRL     = 4'hB;
	localparam logic [3:0] MSG_PITCH    = 4'hE;

	// controller number meaning "all notes off"
	localparam logic [6:0] CTRL_ALL_OFF = 7'd123;

	typedef enum logic [2:0] {
		EV_NOTE_ON  = 3'd0,
		EV_NOTE_OFF = 3'd1,
		EV_RELEASED = 3'd2,
		EV_PITCH    = 3'd3,
		EV_CTRL     = 3'd4
	} ev_kind_t;

	typedef struct packed {
		logic [7:0] status_byte;
		logic [6:0] data_one;
		logic [6:0] data_two;
	} cmd_t;

	typedef struct packed {
		ev_kind_t    event_kind;
		logic [3:0]  channel;
		logic [6:0]  note;
		logic [6:0]  velocity;
		logic [13:0] pitch_value;
		logic [6:0]  ctrl_number;
		logic [6:0]  ctrl_value;
		logic        group;
		logic [63:0] released_mask;
		logic        last;
	} result_t;

	// shared unit operations
	typedef enum logic [1:0] {
		OP_SET = 2'd0,
		OP_CLR = 2'd1,
		OP_EQ  = 2'd2,
		OP_NZ  = 2'd3
	} alu_op_t;

	typedef struct packed {
		alu_op_t            op;
		logic [WORD_W-1:0]  a;
		logic [WORD_W-1:0]  b;
		logic [POS_W-1:0]   pos;
	} alu_req_t;

	typedef struct packed {
		logic [WORD_W-1:0] y;
		logic              flag;
	} alu_rsp_t;

endpackage

// File: rtl/mnst_ram.sv
// Generic single write port RAM with registered read.
`timescale 1ns / 1ps

module mnst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/mnst_alu.sv
// Shared bit set/clear, equality and non-zero unit.
`timescale 1ns / 1ps

module mnst_alu import mnst_pkg::*; (
	input  alu_req_t req,
	output alu_rsp_t rsp
);

	logic [WORD_W-1:0] oh;

	always_comb begin
		oh = '0;
		oh[req.pos] = 1'b1;
		rsp.y = req.a;
		rsp.flag = 1'b0;
		case (req.op)
			OP_SET: begin
				rsp.y = req.a | oh;
				rsp.flag = req.a[req.pos];
			end
			OP_CLR: begin
				rsp.y = req.a & ~oh;
				rsp.flag = req.a[req.pos];
			end
			OP_EQ: begin
				rsp.flag = (req.a == req.b);
			end
			OP_NZ: begin
				rsp.flag = |req.a;
			end
			default: begin
				rsp.flag = 1'b0;
			end
		endcase
	end

endmodule

// File: rtl/midi_note_state_tracker_unit.sv
// MIDI note state tracker: request sequencer, state stores and result register.
//
// A request (status byte, two data bytes on cmd) is taken at a rising edge with
// start high and busy low. Each result appears on result for exactly one cycle
// with strobe high; result.last marks the final result of a request. The
// receiver cannot hold results off.
// Note, pitch and controller requests keep busy high while they are worked on
// and strobe any result in the cycle after; a new request is taken only once
// busy is low again. All notes off makes two reads of the note store through
// its registered read port, then gives up to two group results. Ignored
// messages leave busy low. The registered read of the note and controller
// stores lies ahead of the shared compare unit.
// After reset, busy stays high while the controller store is swept to zero,
// one entry a cycle; note rows and pitch positions clear at once.
`timescale 1ns / 1ps

module midi_note_state_tracker_unit import mnst_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  cmd_t    cmd,
	output logic    busy,
	output logic    strobe,
	output result_t result
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_NOTE,
		ST_AOFF0,
		ST_AOFF1,
		ST_AOFF2,
		ST_PITCH,
		ST_CTRL
	} state_t;

	state_t state_q;
	logic [CTRL_AW-1:0] clr_q;
	logic [3:0] ch_q;
	logic [6:0] d1_q;
	logic [6:0] d2_q;
	logic set_q;
	logic nz0_q;
	logic [WORD_W-1:0] m0_q;
	logic [WORD_W-1:0] m1_q;
	logic row_vld_q;
	logic [NOTE_ROWS-1:0] note_vld_q;
	logic [13:0] pitch_q [NUM_CHANNELS];
	logic strobe_q;
	result_t result_q;

	logic [3:0] in_msg;
	logic [3:0] in_ch;
	logic accept;

	logic note_we;
	logic [NOTE_AW-1:0] note_waddr;
	logic [NOTE_AW-1:0] note_raddr;
	logic [WORD_W-1:0] note_rdata;
	logic [WORD_W-1:0] note_row;

	logic ctrl_we;
	logic [CTRL_AW-1:0] ctrl_waddr;
	logic [7:0] ctrl_wdata;
	logic [CTRL_AW-1:0] ctrl_raddr;
	logic [7:0] ctrl_rdata;

	alu_req_t alu_req;
	alu_rsp_t alu_rsp;

	logic emit;
	result_t res_d;

	assign in_msg = cmd.status_byte[7:4];
	assign in_ch = cmd.status_byte[3:0];
	assign busy = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign strobe = strobe_q;
	assign result = result_q;

	// note rows: a row never written since reset or release reads as zero
	assign note_row = row_vld_q ? note_rdata : '0;
	assign note_waddr = {ch_q, d1_q[6]};
	assign note_we = (state_q == ST_NOTE) && (set_q || alu_rsp.flag);

	always_comb begin
		if (state_q == ST_AOFF0) begin
			note_raddr = {ch_q, 1'b1};
		end else if (in_msg == MSG_CTRL && cmd.data_one == CTRL_ALL_OFF) begin
			note_raddr = {in_ch, 1'b0};
		end else begin
			note_raddr = {in_ch, cmd.data_one[6]};
		end
	end

	mnst_ram #(
		.WIDTH(WORD_W),
		.DEPTH(NOTE_ROWS)
	) u_note_ram (
		.clk  (clk),
		.we   (note_we),
		.waddr(note_waddr),
		.wdata(alu_rsp.y),
		.raddr(note_raddr),
		.rdata(note_rdata)
	);

	// controller store: {known, value}, swept to zero after reset
	assign ctrl_raddr = {in_ch, cmd.data_one};

	always_comb begin
		if (state_q == ST_CLEAR) begin
			ctrl_we = 1'b1;
			ctrl_waddr = clr_q;
			ctrl_wdata = '0;
		end else begin
			ctrl_we = (state_q == ST_CTRL) && !alu_rsp.flag;
			ctrl_waddr = {ch_q, d1_q};
			ctrl_wdata = {1'b1, d2_q};
		end
	end

	mnst_ram #(
		.WIDTH(8),
		.DEPTH(CTRL_DEPTH)
	) u_ctrl_ram (
		.clk  (clk),
		.we   (ctrl_we),
		.waddr(ctrl_waddr),
		.wdata(ctrl_wdata),
		.raddr(ctrl_raddr),
		.rdata(ctrl_rdata)
	);

	// operand selection for the shared unit
	always_comb begin
		alu_req.op = OP_NZ;
		alu_req.a = '0;
		alu_req.b = '0;
		alu_req.pos = d1_q[POS_W-1:0];
		case (state_q)
			ST_NOTE: begin
				alu_req.op = set_q ? OP_SET : OP_CLR;
				alu_req.a = note_row;
			end
			ST_AOFF0, ST_AOFF1: begin
				alu_req.op = OP_NZ;
				alu_req.a = note_row;
			end
			ST_PITCH: begin
				alu_req.op = OP_EQ;
				alu_req.a = {{(WORD_W-14){1'b0}}, pitch_q[ch_q]};
				alu_req.b = {{(WORD_W-14){1'b0}}, d2_q, d1_q};
			end
			ST_CTRL: begin
				alu_req.op = OP_EQ;
				alu_req.a = {{(WORD_W-8){1'b0}}, ctrl_rdata};
				alu_req.b = {{(WORD_W-8){1'b0}}, 1'b1, d2_q};
			end
			default: begin
				alu_req.op = OP_NZ;
			end
		endcase
	end

	mnst_alu u_alu (
		.req(alu_req),
		.rsp(alu_rsp)
	);

	// result selection
	always_comb begin
		emit = 1'b0;
		res_d = '0;
		res_d.channel = ch_q;
		res_d.last = 1'b1;
		case (state_q)
			ST_NOTE: begin
				emit = set_q || alu_rsp.flag;
				res_d.event_kind = set_q ? EV_NOTE_ON : EV_NOTE_OFF;
				res_d.note = d1_q;
				res_d.velocity = d2_q;
			end
			ST_AOFF1: begin
				res_d.event_kind = EV_RELEASED;
				if (nz0_q) begin
					emit = 1'b1;
					res_d.group = 1'b0;
					res_d.released_mask = m0_q;
					res_d.last = !alu_rsp.flag;
				end else begin
					emit = alu_rsp.flag;
					res_d.group = 1'b1;
					res_d.released_mask = note_row;
				end
			end
			ST_AOFF2: begin
				emit = 1'b1;
				res_d.event_kind = EV_RELEASED;
				res_d.group = 1'b1;
				res_d.released_mask = m1_q;
			end
			ST_PITCH: begin
				emit = !alu_rsp.flag;
				res_d.event_kind = EV_PITCH;
				res_d.pitch_value = {d2_q, d1_q};
			end
			ST_CTRL: begin
				emit = !alu_rsp.flag;
				res_d.event_kind = EV_CTRL;
				res_d.ctrl_number = d1_q;
				res_d.ctrl_value = d2_q;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	// sequencer, state stores and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			ch_q <= '0;
			d1_q <= '0;
			d2_q <= '0;
			set_q <= 1'b0;
			nz0_q <= 1'b0;
			m0_q <= '0;
			m1_q <= '0;
			row_vld_q <= 1'b0;
			note_vld_q <= '0;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				pitch_q[i] <= '0;
			end
			strobe_q <= 1'b0;
			result_q <= '0;
		end else begin
			row_vld_q <= note_vld_q[note_raddr];
			strobe_q <= emit;
			if (emit) begin
				result_q <= res_d;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CTRL_AW'(CTRL_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						ch_q <= in_ch;
						d1_q <= cmd.data_one;
						d2_q <= cmd.data_two;
						set_q <= (in_msg == MSG_NOTE_ON) && (cmd.data_two != '0);
						case (in_msg)
							MSG_NOTE_OFF, MSG_NOTE_ON: begin
								state_q <= ST_NOTE;
							end
							MSG_CTRL: begin
								state_q <= (cmd.data_one == CTRL_ALL_OFF) ? ST_AOFF0 : ST_CTRL;
							end
							MSG_PITCH: begin
								state_q <= ST_PITCH;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_NOTE: begin
					if (note_we) begin
						note_vld_q[note_waddr] <= 1'b1;
					end
					state_q <= ST_IDLE;
				end
				ST_AOFF0: begin
					nz0_q <= alu_rsp.flag;
					m0_q <= note_row;
					state_q <= ST_AOFF1;
				end
				ST_AOFF1: begin
					m1_q <= note_row;
					// both rows of the channel read as empty from here on
					note_vld_q <= note_vld_q & ~(NOTE_ROWS'(2'b11) << {ch_q, 1'b0});
					state_q <= (nz0_q && alu_rsp.flag) ? ST_AOFF2 : ST_IDLE;
				end
				ST_AOFF2: begin
					state_q <= ST_IDLE;
				end
				ST_PITCH: begin
					if (!alu_rsp.flag) begin
						pitch_q[ch_q] <= {d2_q, d1_q};
					end
					state_q <= ST_IDLE;
				end
				ST_CTRL: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	// a result is only produced by work begun in an earlier cycle
	a_strobe_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy))
		else $error("result strobe without preceding work");

	// a non-final result is always followed by its partner
	a_group_pair: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last |=> strobe && result.last)
		else $error("second released group missing");

	// released groups never carry an empty mask
	a_mask_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.event_kind == EV_RELEASED |-> result.released_mask != '0)
		else $error("empty released group reported");
`endif

endmodule
